FILE: design/jsdz_pkg.sv
`default_nettype none

package jsdz_pkg;

    localparam logic [1:0] REQ_SAMPLE  = 2'd0;
    localparam logic [1:0] REQ_READ    = 2'd1;
    localparam logic [1:0] REQ_RESTART = 2'd2;

    localparam logic [2:0] EV_NEW_DATA = 3'd7;

    localparam logic [7:0] DECODE_KEY = 8'h17;

    localparam int unsigned PADDR_W = 5;

    localparam logic [2:0] REG_CENTER_X    = 3'd0;
    localparam logic [2:0] REG_CENTER_Y    = 3'd1;
    localparam logic [2:0] REG_DEAD_ZONE   = 3'd2;
    localparam logic [2:0] REG_CLAMP_LIMIT = 3'd3;
    localparam logic [2:0] REG_DIR_THRESH  = 3'd4;
    localparam logic [2:0] REG_WARMUP      = 3'd5;

    localparam logic [7:0] RST_CENTER_X    = 8'd124;
    localparam logic [7:0] RST_CENTER_Y    = 8'd132;
    localparam logic [6:0] RST_DEAD_ZONE   = 7'd20;
    localparam logic [6:0] RST_CLAMP_LIMIT = 7'd100;
    localparam logic [6:0] RST_DIR_THRESH  = 7'd70;
    localparam logic [7:0] RST_WARMUP      = 8'd20;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] joy_x;
        logic [7:0] joy_y;
        logic [7:0] buttons_byte;
        logic [2:0] event_index;
    } t_in_word;

    typedef struct packed {
        logic signed [7:0] centered_x;
        logic signed [7:0] centered_y;
        logic [6:0]        direction_states;
        logic [6:0]        pending_events;
        logic              event_value;
        logic              new_data;
    } t_out_word;

    typedef struct packed {
        logic [7:0] center_x;
        logic [7:0] center_y;
        logic [6:0] dead_zone;
        logic [6:0] clamp_limit;
        logic [6:0] direction_threshold;
        logic [7:0] warmup_samples;
    } t_cfg;

    typedef struct packed {
        logic signed [7:0] value;
        logic              pos;
        logic              neg;
    } t_axis_res;

endpackage

`default_nettype wire

FILE: design/jsdz_cfg_regs.sv
`default_nettype none

module jsdz_cfg_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [jsdz_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [31:0]                      pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,
    output jsdz_pkg::t_cfg                        o_cfg
);

    jsdz_pkg::t_cfg r_cfg;
    logic [2:0]     reg_idx;
    logic           wr_en;

    assign reg_idx = paddr[jsdz_pkg::PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x            <= jsdz_pkg::RST_CENTER_X;
            r_cfg.center_y            <= jsdz_pkg::RST_CENTER_Y;
            r_cfg.dead_zone           <= jsdz_pkg::RST_DEAD_ZONE;
            r_cfg.clamp_limit         <= jsdz_pkg::RST_CLAMP_LIMIT;
            r_cfg.direction_threshold <= jsdz_pkg::RST_DIR_THRESH;
            r_cfg.warmup_samples      <= jsdz_pkg::RST_WARMUP;
        end else if (wr_en) begin
            case (reg_idx)
                jsdz_pkg::REG_CENTER_X:    r_cfg.center_x            <= pwdata[7:0];
                jsdz_pkg::REG_CENTER_Y:    r_cfg.center_y            <= pwdata[7:0];
                jsdz_pkg::REG_DEAD_ZONE:   r_cfg.dead_zone           <= pwdata[6:0];
                jsdz_pkg::REG_CLAMP_LIMIT: r_cfg.clamp_limit         <= pwdata[6:0];
                jsdz_pkg::REG_DIR_THRESH:  r_cfg.direction_threshold <= pwdata[6:0];
                jsdz_pkg::REG_WARMUP:      r_cfg.warmup_samples      <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            jsdz_pkg::REG_CENTER_X:    prdata = {24'd0, r_cfg.center_x};
            jsdz_pkg::REG_CENTER_Y:    prdata = {24'd0, r_cfg.center_y};
            jsdz_pkg::REG_DEAD_ZONE:   prdata = {25'd0, r_cfg.dead_zone};
            jsdz_pkg::REG_CLAMP_LIMIT: prdata = {25'd0, r_cfg.clamp_limit};
            jsdz_pkg::REG_DIR_THRESH:  prdata = {25'd0, r_cfg.direction_threshold};
            jsdz_pkg::REG_WARMUP:      prdata = {24'd0, r_cfg.warmup_samples};
            default:                   prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

FILE: design/jsdz_axis_filter.sv
`default_nettype none

module jsdz_axis_filter (
    input  wire logic [7:0]  i_raw,
    input  wire logic [7:0]  i_center,
    input  wire logic [6:0]  i_dead_zone,
    input  wire logic [6:0]  i_clamp_limit,
    input  wire logic [6:0]  i_threshold,
    output jsdz_pkg::t_axis_res o_res
);

    logic signed [9:0] diff;
    logic signed [9:0] dz;
    logic signed [9:0] lim;
    logic signed [9:0] th;
    logic signed [9:0] val;

    always_comb begin
        diff = signed'({2'b00, i_raw}) - signed'({2'b00, i_center});
        dz   = signed'({3'b000, i_dead_zone});
        lim  = signed'({3'b000, i_clamp_limit});
        th   = signed'({3'b000, i_threshold});
        val  = diff;
        if (val > -dz && val < dz) begin
            val = '0;
        end
        if (val > lim) begin
            val = lim;
        end
        if (val < -lim) begin
            val = -lim;
        end
        o_res.value = val[7:0];
        o_res.pos   = val > th;
        o_res.neg   = val < -th;
    end

endmodule

`default_nettype wire

FILE: design/joystick_deadzone_dpad_events.sv
// Joystick dead zone filter with sticky direction and button events.
//
// The input channel (i_in_valid, o_in_stall, i_in_word) carries one word per
// request: a sample, a read-and-clear of one event bit, or a restart. The
// output channel (o_out_valid, i_out_stall, o_out_word) returns exactly one
// word for every accepted request, in order.
// A word is registered in the input register on acceptance; once the output
// can advance, it is processed and its result is registered in the result
// register, from which the receiver takes it.
// The block sustains one word per cycle while the receiver does not stall: the
// input register and the result register form a two-entry pipeline, and the
// whole update of the filter and event state is combinational logic between them.
// When the receiver stalls, the result is held unchanged and one more word
// is still taken into the input register; o_in_stall rises only when both
// registers are full and the output is stalled.
// Reset loads the register defaults, starts the warm-up count and clears the
// events, the new data flag and the held axis values.
// The user must write configuration through the APB-style port only while no
// request is in flight; the block does not enforce this. pready is always high.
`default_nettype none

module joystick_deadzone_dpad_events (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire jsdz_pkg::t_in_word            i_in_word,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output jsdz_pkg::t_out_word                o_out_word,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [jsdz_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    jsdz_pkg::t_cfg      cfg;
    jsdz_pkg::t_axis_res ax;
    jsdz_pkg::t_axis_res ay;

    logic                r_s1_valid;
    jsdz_pkg::t_in_word  r_s1;
    logic                r_out_valid;
    jsdz_pkg::t_out_word r_out;

    logic [7:0]        r_warm,    n_warm;
    logic [6:0]        r_prev,    n_prev;
    logic [6:0]        r_latched, n_latched;
    logic              r_new,     n_new;
    logic signed [7:0] r_held_x,  n_held_x;
    logic signed [7:0] r_held_y,  n_held_y;
    logic              n_ev;

    logic       out_adv;
    logic       s1_fire;
    logic       in_fire;
    logic [7:0] dec;
    logic       btn_z;
    logic       btn_c;
    logic [6:0] cur;
    logic [6:0] ev_shift;

    jsdz_cfg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    jsdz_axis_filter u_filt_x (
        .i_raw         (r_s1.joy_x),
        .i_center      (cfg.center_x),
        .i_dead_zone   (cfg.dead_zone),
        .i_clamp_limit (cfg.clamp_limit),
        .i_threshold   (cfg.direction_threshold),
        .o_res         (ax)
    );

    jsdz_axis_filter u_filt_y (
        .i_raw         (r_s1.joy_y),
        .i_center      (cfg.center_y),
        .i_dead_zone   (cfg.dead_zone),
        .i_clamp_limit (cfg.clamp_limit),
        .i_threshold   (cfg.direction_threshold),
        .o_res         (ay)
    );

    assign out_adv     = !r_out_valid || !i_out_stall;
    assign s1_fire     = r_s1_valid && out_adv;
    assign o_in_stall  = r_s1_valid && !out_adv;
    assign in_fire     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    always_comb begin
        dec      = (r_s1.buttons_byte ^ jsdz_pkg::DECODE_KEY) + jsdz_pkg::DECODE_KEY;
        btn_z    = !dec[0];
        btn_c    = !dec[1];
        cur      = {btn_z && btn_c, btn_c, btn_z, ay.pos, ay.neg, ax.neg, ax.pos};
        ev_shift = r_latched >> r_s1.event_index;

        n_warm    = r_warm;
        n_prev    = r_prev;
        n_latched = r_latched;
        n_new     = r_new;
        n_held_x  = r_held_x;
        n_held_y  = r_held_y;
        n_ev      = 1'b0;

        case (r_s1.req_type)
            jsdz_pkg::REQ_SAMPLE: begin
                if (r_warm != 8'd0) begin
                    n_warm   = r_warm - 8'd1;
                    n_held_x = '0;
                    n_held_y = '0;
                end else begin
                    n_held_x  = ax.value;
                    n_held_y  = ay.value;
                    n_latched = r_latched | (cur & ~r_prev);
                    n_prev    = cur;
                    n_new     = 1'b1;
                end
            end
            jsdz_pkg::REQ_READ: begin
                if (r_s1.event_index == jsdz_pkg::EV_NEW_DATA) begin
                    n_ev  = r_new;
                    n_new = 1'b0;
                end else begin
                    n_ev      = ev_shift[0];
                    n_latched = r_latched & ~(7'd1 << r_s1.event_index);
                end
            end
            jsdz_pkg::REQ_RESTART: begin
                n_warm    = cfg.warmup_samples;
                n_latched = '0;
                n_new     = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_warm      <= jsdz_pkg::RST_WARMUP;
            r_prev      <= '0;
            r_latched   <= '0;
            r_new       <= 1'b0;
            r_held_x    <= '0;
            r_held_y    <= '0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (out_adv) begin
                r_out_valid <= r_s1_valid;
            end
            if (s1_fire) begin
                r_warm    <= n_warm;
                r_prev    <= n_prev;
                r_latched <= n_latched;
                r_new     <= n_new;
                r_held_x  <= n_held_x;
                r_held_y  <= n_held_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1 <= i_in_word;
        end
        if (s1_fire) begin
            r_out.centered_x       <= n_held_x;
            r_out.centered_y       <= n_held_y;
            r_out.direction_states <= n_prev;
            r_out.pending_events   <= n_latched;
            r_out.event_value      <= n_ev;
            r_out.new_data         <= n_new;
        end
    end

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid && i_out_stall))
        else $error("input stalled while the pipeline has room");

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_s1.req_type == jsdz_pkg::REQ_RESTART)
        |=> (r_latched == 7'd0 && !r_new && r_warm == $past(cfg.warmup_samples)))
        else $error("restart did not clear events or reload warm-up count");

    a_warmup_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_s1.req_type == jsdz_pkg::REQ_SAMPLE && r_warm != 8'd0)
        |=> (r_held_x == 8'sd0 && r_held_y == 8'sd0 && $stable(r_prev)))
        else $error("sample during warm-up changed the filtered state");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.centered_x != 8'sh80 && o_out_word.centered_y != 8'sh80))
        else $error("centered value outside the clamp range");

endmodule

`default_nettype wire

FILE: verif/tb_joystick_deadzone_dpad_events.sv
`timescale 1ns / 100ps

module tb_joystick_deadzone_dpad_events;

    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 300000;

    class jsdz_event_tracker;
        jsdz_pkg::t_cfg      cfg;
        logic [7:0]          warmup_left;
        logic [6:0]          prev_states;
        logic [6:0]          latched_events;
        logic                new_data_flag;
        logic signed [7:0]   held_x;
        logic signed [7:0]   held_y;
        jsdz_pkg::t_out_word expected_words[$];
        int                  mismatches;
        int                  words_taken;

        function new();
            cfg = '{jsdz_pkg::RST_CENTER_X, jsdz_pkg::RST_CENTER_Y,
                    jsdz_pkg::RST_DEAD_ZONE, jsdz_pkg::RST_CLAMP_LIMIT,
                    jsdz_pkg::RST_DIR_THRESH, jsdz_pkg::RST_WARMUP};
            warmup_left    = jsdz_pkg::RST_WARMUP;
            prev_states    = '0;
            latched_events = '0;
            new_data_flag  = 1'b0;
            held_x         = '0;
            held_y         = '0;
            mismatches     = 0;
            words_taken    = 0;
        endfunction

        function void set_register(logic [2:0] idx, logic [31:0] value);
            case (idx)
                jsdz_pkg::REG_CENTER_X:    cfg.center_x = value[7:0];
                jsdz_pkg::REG_CENTER_Y:    cfg.center_y = value[7:0];
                jsdz_pkg::REG_DEAD_ZONE:   cfg.dead_zone = value[6:0];
                jsdz_pkg::REG_CLAMP_LIMIT: cfg.clamp_limit = value[6:0];
                jsdz_pkg::REG_DIR_THRESH:  cfg.direction_threshold = value[6:0];
                jsdz_pkg::REG_WARMUP:      cfg.warmup_samples = value[7:0];
                default: ;
            endcase
        endfunction

        // The dead zone is applied before the clamp, so a dead zone wider than
        // the clamp limit still passes large deflections at the clamp value.
        function logic signed [7:0] center_axis(logic [7:0] raw, logic [7:0] mid);
            int v;
            int dz;
            int lim;
            v   = int'(raw) - int'(mid);
            dz  = int'(cfg.dead_zone);
            lim = int'(cfg.clamp_limit);
            if (v > -dz && v < dz) v = 0;
            if (v > lim) v = lim;
            if (v < -lim) v = -lim;
            return 8'(v);
        endfunction

        function void note_input(jsdz_pkg::t_in_word w);
            jsdz_pkg::t_out_word res;
            logic [7:0]          dec;
            logic [6:0]          cur;
            logic                z;
            logic                c;
            int                  th;
            int                  hx;
            int                  hy;
            res = '0;
            case (w.req_type)
                jsdz_pkg::REQ_SAMPLE: begin
                    if (warmup_left != 0) begin
                        warmup_left = warmup_left - 8'd1;
                        held_x = '0;
                        held_y = '0;
                    end else begin
                        dec    = (w.buttons_byte ^ jsdz_pkg::DECODE_KEY) + jsdz_pkg::DECODE_KEY;
                        z      = ~dec[0];
                        c      = ~dec[1];
                        th     = int'(cfg.direction_threshold);
                        held_x = center_axis(w.joy_x, cfg.center_x);
                        held_y = center_axis(w.joy_y, cfg.center_y);
                        hx     = int'(held_x);
                        hy     = int'(held_y);
                        cur    = {z & c, c, z, hy > th, hy < -th, hx < -th, hx > th};
                        latched_events = latched_events | (cur & ~prev_states);
                        prev_states    = cur;
                        new_data_flag  = 1'b1;
                    end
                end
                jsdz_pkg::REQ_READ: begin
                    if (w.event_index == jsdz_pkg::EV_NEW_DATA) begin
                        res.event_value = new_data_flag;
                        new_data_flag   = 1'b0;
                    end else begin
                        res.event_value = latched_events[w.event_index];
                        latched_events[w.event_index] = 1'b0;
                    end
                end
                jsdz_pkg::REQ_RESTART: begin
                    warmup_left    = cfg.warmup_samples;
                    latched_events = '0;
                    new_data_flag  = 1'b0;
                end
                default: ;
            endcase
            res.centered_x       = held_x;
            res.centered_y       = held_y;
            res.direction_states = prev_states;
            res.pending_events   = latched_events;
            res.new_data         = new_data_flag;
            expected_words.push_back(res);
            words_taken++;
        endfunction

        function void check_result(jsdz_pkg::t_out_word got);
            jsdz_pkg::t_out_word want;
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Result word with no request pending: x=%0d y=%0d dir=%02h ev=%02h",
                             got.centered_x, got.centered_y, got.direction_states,
                             got.pending_events);
                end
                return;
            end
            want = expected_words.pop_front();
            if (want.centered_x !== got.centered_x || want.centered_y !== got.centered_y ||
                want.direction_states !== got.direction_states ||
                want.pending_events !== got.pending_events ||
                want.event_value !== got.event_value || want.new_data !== got.new_data) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Mismatch: expected x=%0d y=%0d dir=%02h ev=%02h val=%0b nd=%0b",
                             want.centered_x, want.centered_y, want.direction_states,
                             want.pending_events, want.event_value, want.new_data);
                    $display("          got      x=%0d y=%0d dir=%02h ev=%02h val=%0b nd=%0b",
                             got.centered_x, got.centered_y, got.direction_states,
                             got.pending_events, got.event_value, got.new_data);
                end
            end
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n     = 1'b0;
    logic                          i_in_valid  = 1'b0;
    logic                          o_in_stall;
    jsdz_pkg::t_in_word            i_in_word   = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    jsdz_pkg::t_out_word           o_out_word;
    logic                          psel        = 1'b0;
    logic                          penable     = 1'b0;
    logic                          pwrite      = 1'b0;
    logic [jsdz_pkg::PADDR_W-1:0]  paddr       = '0;
    logic [31:0]                   pwdata      = '0;
    logic [31:0]                   prdata;
    logic                          pready;

    jsdz_event_tracker             tracker;
    int                            cycle_count = 0;

    joystick_deadzone_dpad_events u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) tracker.check_result(o_out_word);
        end
    end

    // Receiver: runs of no, light or heavy stalling, plus one long hold-off
    // once enough words have gone in, so that the block backs up.
    initial begin
        int  run_left;
        int  mode;
        int  hold;
        bit  held_off;
        bit  stall_now;
        run_left = 0;
        mode     = 0;
        hold     = 0;
        held_off = 1'b0;
        forever begin
            @(posedge i_clk);
            if (run_left == 0) begin
                run_left = $urandom_range(8, 40);
                mode     = $urandom_range(0, 2);
            end
            run_left--;
            if (hold > 0) begin
                hold--;
            end else if (!held_off && tracker.words_taken >= 150) begin
                held_off = 1'b1;
                hold     = 80;
            end
            case (mode)
                0:       stall_now = 1'b0;
                1:       stall_now = ($urandom_range(0, 3) == 0);
                default: stall_now = ($urandom_range(0, 3) != 0);
            endcase
            i_out_stall <= (hold > 0) || stall_now;
        end
    end

    function automatic jsdz_pkg::t_in_word make_word(logic [1:0] req, logic [7:0] x,
                                                     logic [7:0] y, logic [7:0] bb,
                                                     logic [2:0] idx);
        jsdz_pkg::t_in_word w;
        w.req_type     = req;
        w.joy_x        = x;
        w.joy_y        = y;
        w.buttons_byte = bb;
        w.event_index  = idx;
        return w;
    endfunction

    function automatic jsdz_pkg::t_in_word random_word(bit allow_restart);
        int         r;
        logic [1:0] req;
        logic [7:0] x;
        logic [7:0] y;
        r = $urandom_range(0, 99);
        if (r < 55) req = jsdz_pkg::REQ_SAMPLE;
        else if (r < 88) req = jsdz_pkg::REQ_READ;
        else if (r < 94) req = allow_restart ? jsdz_pkg::REQ_RESTART : jsdz_pkg::REQ_SAMPLE;
        else req = REQ_UNUSED;
        x = 8'($urandom_range(0, 255));
        y = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 7) == 0) x = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        if ($urandom_range(0, 7) == 0) y = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        return make_word(req, x, y, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
    endfunction

    task automatic send_word(input jsdz_pkg::t_in_word w);
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        tracker.note_input(w);
    endtask

    task automatic send_random_words(input int count, input bit allow_restart);
        int left;
        int burst;
        int gap;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 16);
            if (burst > left) burst = left;
            repeat (burst) send_word(random_word(allow_restart));
            left -= burst;
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (tracker.expected_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        tracker.set_register(idx, value);
    endtask

    task automatic release_bus();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_all_registers(input jsdz_pkg::t_cfg c);
        write_register(jsdz_pkg::REG_CENTER_X, 32'(c.center_x));
        write_register(jsdz_pkg::REG_CENTER_Y, 32'(c.center_y));
        write_register(jsdz_pkg::REG_DEAD_ZONE, 32'(c.dead_zone));
        write_register(jsdz_pkg::REG_CLAMP_LIMIT, 32'(c.clamp_limit));
        write_register(jsdz_pkg::REG_DIR_THRESH, 32'(c.direction_threshold));
        write_register(jsdz_pkg::REG_WARMUP, 32'(c.warmup_samples));
        release_bus();
    endtask

    initial begin
        jsdz_pkg::t_cfg c;
        tracker = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Still warming up after reset, then the unused request type.
        send_word(make_word(jsdz_pkg::REQ_SAMPLE, 8'd255, 8'd0, 8'hFF, 3'd0));
        send_word(make_word(jsdz_pkg::REQ_READ, 8'd0, 8'd0, 8'd0, jsdz_pkg::EV_NEW_DATA));
        send_word(make_word(REQ_UNUSED, 8'd255, 8'd255, 8'hFF, 3'd7));
        wait_idle();

        // A new warm-up length only applies from the next restart.
        write_register(jsdz_pkg::REG_WARMUP, 32'd0);
        release_bus();
        send_word(make_word(jsdz_pkg::REQ_SAMPLE, 8'd0, 8'd255, 8'h00, 3'd0));
        send_word(make_word(jsdz_pkg::REQ_RESTART, 8'd0, 8'd0, 8'd0, 3'd0));
        send_word(make_word(jsdz_pkg::REQ_SAMPLE, 8'd124, 8'd132, 8'hFB, 3'd0));
        send_word(make_word(jsdz_pkg::REQ_SAMPLE, 8'd255, 8'd0, 8'h00, 3'd0));
        send_word(make_word(jsdz_pkg::REQ_SAMPLE, 8'd0, 8'd255, 8'hFF, 3'd0));
        send_word(make_word(jsdz_pkg::REQ_SAMPLE, 8'd143, 8'd113, 8'h17, 3'd0));
        send_word(make_word(jsdz_pkg::REQ_SAMPLE, 8'd144, 8'd112, 8'hE8, 3'd0));
        send_word(make_word(jsdz_pkg::REQ_SAMPLE, 8'd195, 8'd202, 8'h14, 3'd0));
        for (int i = 0; i < 8; i++) begin
            send_word(make_word(jsdz_pkg::REQ_READ, 8'd0, 8'd0, 8'd0, 3'(i)));
        end
        send_word(make_word(jsdz_pkg::REQ_SAMPLE, 8'd0, 8'd0, 8'h00, 3'd0));
        send_word(make_word(jsdz_pkg::REQ_RESTART, 8'd0, 8'd0, 8'd0, 3'd0));
        wait_idle();

        write_register(jsdz_pkg::REG_DEAD_ZONE, 32'd100);
        write_register(jsdz_pkg::REG_CLAMP_LIMIT, 32'd50);
        write_register(jsdz_pkg::REG_DIR_THRESH, 32'd40);
        release_bus();
        send_word(make_word(jsdz_pkg::REQ_SAMPLE, 8'd223, 8'd32, 8'h55, 3'd0));
        send_word(make_word(jsdz_pkg::REQ_SAMPLE, 8'd224, 8'd132, 8'hAA, 3'd0));
        send_word(make_word(jsdz_pkg::REQ_READ, 8'd0, 8'd0, 8'd0, 3'd0));
        wait_idle();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: c = '{8'd0, 8'd255, 7'd0, 7'd0, 7'd0, 8'd0};
                1: c = '{8'd255, 8'd0, 7'd127, 7'd127, 7'd127, 8'd3};
                default: begin
                    c.center_x            = 8'($urandom_range(90, 166));
                    c.center_y            = 8'($urandom_range(90, 166));
                    c.dead_zone           = 7'($urandom_range(0, 40));
                    c.clamp_limit         = 7'($urandom_range(30, 127));
                    c.direction_threshold = 7'($urandom_range(0, 110));
                    c.warmup_samples      = (p == 3) ? 8'd255 : 8'($urandom_range(0, 4));
                end
            endcase
            write_all_registers(c);
            if (p != 3) send_word(make_word(jsdz_pkg::REQ_RESTART, 8'($urandom_range(0, 255)),
                                            8'($urandom_range(0, 255)),
                                            8'($urandom_range(0, 255)),
                                            3'($urandom_range(0, 7))));
            send_random_words(60, p != 3);
            wait_idle();
        end

        if (tracker.mismatches == 0 && tracker.expected_words.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
